// ----- rtl/core/assert_macros.svh -----
// assertion macros for the rtl files, included by matrix_multiply_accumulate
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clk_i, off while rst_ni is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same, with an explicit enable that gates the check
`define ASSERT_CLK_IF(label, en, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) ((en) |-> (prop))) \
    else $error(msg);

`endif

// ----- rtl/core/mma_pkg.sv -----
// constants and defaults for the matrix multiply-accumulate block
`timescale 1ns / 1ps

package mma_pkg;

  localparam int unsigned MaxInnerDef  = 64;
  localparam int unsigned MaxColsDef   = 16;
  localparam int unsigned DataWidthDef = 16;

  // fixed field widths of the result item
  localparam int unsigned SumW      = 40;
  localparam int unsigned ColW      = 4;
  localparam int unsigned OutTdataW = ((SumW + ColW + 7) / 8) * 8;

  // configuration register widths and indexes
  localparam int unsigned InnerLenW = 7;
  localparam int unsigned OutColsW  = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 7;

  localparam logic [CfgIdxW-1:0] CfgInnerLen = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOutCols  = 2'd1;

  // pipeline stage tag: valid and last column of the sweep
  typedef struct packed {
    logic vld;
    logic last;
  } mma_stage_t;

endpackage

// ----- rtl/core/mma_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module mma_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/matrix_multiply_accumulate.sv -----
// streaming matrix multiply: weight store, shared multiply-accumulate unit, result output
`timescale 1ns / 1ps

// A weight item (tuser 0) is written into the weight store in row-major
// order. A left-row element (tuser 1) is multiplied against the current
// weight row by one shared multiplier and one saturating 40-bit adder, one
// output column per cycle, through the ram read and product registers; no new
// item is taken until the element has been accumulated. After the
// last element of a row the out_cols sums leave one per cycle through an
// output register, column 0 first, tlast on the final column; back-pressure on
// the output stretches that phase. Sums are Q24.16 and clamp at each addition.
// Configuration writes clear the accumulators and the load and row positions
// but keep the weights; write them only while no item is in flight.
module matrix_multiply_accumulate
  import mma_pkg::*;
#(
  parameter int unsigned MAX_INNER  = MaxInnerDef,
  parameter int unsigned MAX_COLS   = MaxColsDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]                    cfg_index_i,
  input  logic [CfgDataW-1:0]                   cfg_data_i,
  // input items
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata_i,  // value, zero pad
  input  logic                                  s_axis_tuser_i,  // kind
  // result items
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [OutTdataW-1:0]                  m_axis_tdata_o,  // sum, column, zero pad
  output logic                                  m_axis_tlast_o
);

  `include "assert_macros.svh"

  localparam int unsigned Depth    = MAX_INNER * MAX_COLS;
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned TotW     = $clog2(Depth + 1);
  localparam int unsigned ColIdxW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ColCntW  = $clog2(MAX_COLS + 1);
  localparam int unsigned InCntW   = $clog2(MAX_INNER + 1);
  localparam int unsigned ProdW    = 2 * DATA_WIDTH;
  localparam int unsigned ExtW     = ((ProdW > SumW) ? ProdW : SumW) + 1;

  localparam logic [ExtW-1:0] SatHi = {{(ExtW-SumW+1){1'b0}}, {(SumW-1){1'b1}}};
  localparam logic [ExtW-1:0] SatLo = {{(ExtW-SumW+1){1'b1}}, {(SumW-1){1'b0}}};

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMac  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [InnerLenW-1:0]  inner_len_q;
  logic [OutColsW-1:0]   out_cols_q;
  logic [InCntW-1:0]     eff_inner;
  logic [ColCntW-1:0]    eff_cols;
  logic [ColIdxW-1:0]    cols_m1;
  logic [TotW-1:0]       total;

  logic [AddrW-1:0]      load_ptr_q;
  logic [InCntW-1:0]     inner_cnt_q;
  logic [AddrW-1:0]      row_base_q;
  logic [AddrW-1:0]      cur_base_q;
  logic                  row_end_q;
  logic signed [DATA_WIDTH-1:0] value_q;

  logic                  issuing_q;
  logic [ColIdxW-1:0]    issue_col_q;
  mma_stage_t            s1_q, s2_q;
  logic [ColIdxW-1:0]    s1_col_q, s2_col_q;
  logic signed [ProdW-1:0] prod_q;

  logic [SumW-1:0]       acc_q [MAX_COLS];
  logic [ExtW-1:0]       sum_ext;
  logic [SumW-1:0]       sum_sat;

  logic [ColIdxW-1:0]    emit_col_q;
  logic                  m_valid_q;
  logic [SumW-1:0]       out_sum_q;
  logic [ColIdxW-1:0]    out_col_q;
  logic                  out_last_q;

  logic                  cfg_fire, in_fire, wgt_fire, elem_fire, emit_load;
  logic [DATA_WIDTH-1:0] rdata;
  logic [ColW-1:0]       out_col_w;

  // effective shape, clamped to the supported range
  always_comb begin
    if (inner_len_q == '0) begin
      eff_inner = InCntW'(1);
    end else if (32'(inner_len_q) > MAX_INNER) begin
      eff_inner = InCntW'(MAX_INNER);
    end else begin
      eff_inner = InCntW'(inner_len_q);
    end
    if (out_cols_q == '0) begin
      eff_cols = ColCntW'(1);
    end else if (32'(out_cols_q) > MAX_COLS) begin
      eff_cols = ColCntW'(MAX_COLS);
    end else begin
      eff_cols = ColCntW'(out_cols_q);
    end
  end

  assign cols_m1 = ColIdxW'(eff_cols - ColCntW'(1));
  assign total   = TotW'(eff_inner) * TotW'(eff_cols);

  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign wgt_fire        = in_fire & ~s_axis_tuser_i;
  assign elem_fire       = in_fire & s_axis_tuser_i;
  assign emit_load       = (state_q == StEmit) & (~m_valid_q | m_axis_tready_i);

  mma_ram #(
    .Width (DATA_WIDTH),
    .Depth (Depth)
  ) u_wstore (
    .clk_i   (clk_i),
    .we_i    (wgt_fire),
    .waddr_i (load_ptr_q),
    .wdata_i (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .re_i    (issuing_q),
    .raddr_i (cur_base_q + AddrW'(issue_col_q)),
    .rdata_o (rdata)
  );

  // saturating accumulate of the registered product
  always_comb begin
    sum_ext = {{(ExtW-SumW){acc_q[s2_col_q][SumW-1]}}, acc_q[s2_col_q]}
            + {{(ExtW-ProdW){prod_q[ProdW-1]}}, prod_q};
    if ($signed(sum_ext) > $signed(SatHi)) begin
      sum_sat = SatHi[SumW-1:0];
    end else if ($signed(sum_ext) < $signed(SatLo)) begin
      sum_sat = SatLo[SumW-1:0];
    end else begin
      sum_sat = sum_ext[SumW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (elem_fire) begin
          state_d = StMac;
        end
      end
      StMac: begin
        if (s2_q.vld && s2_q.last) begin
          state_d = row_end_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (emit_load && emit_col_q == cols_m1) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      inner_len_q <= InnerLenW'(1);
      out_cols_q  <= OutColsW'(1);
      load_ptr_q  <= '0;
      inner_cnt_q <= '0;
      row_base_q  <= '0;
      cur_base_q  <= '0;
      row_end_q   <= 1'b0;
      issuing_q   <= 1'b0;
      issue_col_q <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      s1_col_q    <= '0;
      s2_col_q    <= '0;
      emit_col_q  <= '0;
      m_valid_q   <= 1'b0;
      for (int i = 0; i < MAX_COLS; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_fire) begin
        if (cfg_index_i == CfgInnerLen) begin
          inner_len_q <= cfg_data_i[InnerLenW-1:0];
        end
        if (cfg_index_i == CfgOutCols) begin
          out_cols_q <= cfg_data_i[OutColsW-1:0];
        end
        if (cfg_index_i == CfgInnerLen || cfg_index_i == CfgOutCols) begin
          load_ptr_q  <= '0;
          inner_cnt_q <= '0;
          row_base_q  <= '0;
          for (int i = 0; i < MAX_COLS; i++) begin
            acc_q[i] <= '0;
          end
        end
      end

      // weight load, wrapping after a full matrix
      if (wgt_fire) begin
        if (TotW'(load_ptr_q) + TotW'(1) >= total) begin
          load_ptr_q <= '0;
        end else begin
          load_ptr_q <= load_ptr_q + AddrW'(1);
        end
      end

      // start of one element: latch value and weight row, advance row position
      if (elem_fire) begin
        cur_base_q  <= row_base_q;
        issuing_q   <= 1'b1;
        issue_col_q <= '0;
        if (inner_cnt_q + InCntW'(1) >= eff_inner) begin
          row_end_q   <= 1'b1;
          inner_cnt_q <= '0;
          row_base_q  <= '0;
        end else begin
          row_end_q   <= 1'b0;
          inner_cnt_q <= inner_cnt_q + InCntW'(1);
          row_base_q  <= row_base_q + AddrW'(eff_cols);
        end
      end

      // column sweep through ram read, product and accumulate stages
      if (issuing_q) begin
        if (issue_col_q == cols_m1) begin
          issuing_q <= 1'b0;
        end
        issue_col_q <= issue_col_q + ColIdxW'(1);
      end
      s1_q.vld  <= issuing_q;
      s1_q.last <= issuing_q & (issue_col_q == cols_m1);
      s1_col_q  <= issue_col_q;
      s2_q      <= s1_q;
      s2_col_q  <= s1_col_q;
      if (s2_q.vld) begin
        acc_q[s2_col_q] <= sum_sat;
      end

      // result output, clearing each accumulator as it leaves
      if (state_q == StMac) begin
        emit_col_q <= '0;
      end
      if (emit_load) begin
        m_valid_q       <= 1'b1;
        acc_q[emit_col_q] <= '0;
        emit_col_q      <= emit_col_q + ColIdxW'(1);
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (elem_fire) begin
      value_q <= $signed(s_axis_tdata_i[DATA_WIDTH-1:0]);
    end
    if (s1_q.vld) begin
      prod_q <= value_q * $signed(rdata);
    end
    if (emit_load) begin
      out_sum_q  <= acc_q[emit_col_q];
      out_col_q  <= emit_col_q;
      out_last_q <= (emit_col_q == cols_m1);
    end
  end

  assign out_col_w       = ColW'(32'(out_col_q));
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(OutTdataW-SumW-ColW){1'b0}}, out_col_w, out_sum_q};

  `ASSERT_CLK(a_ptr_in_matrix, TotW'(load_ptr_q) < total,
    "weight load pointer beyond matrix")
  `ASSERT_CLK_IF(a_last_on_final_col, m_valid_q && out_last_q, out_col_q == cols_m1,
    "tlast on a column other than the final one")
  `ASSERT_CLK_IF(a_stage_col_follows, s2_q.vld, s2_col_q == $past(s1_col_q),
    "accumulate stage lost its column tag")
  `ASSERT_CLK_IF(a_no_input_while_busy, state_q != StIdle, !issuing_q || !in_fire,
    "item accepted during column sweep")

endmodule
